### rtl/core/pra_pkg.sv
`default_nettype none
package pra_pkg;
    localparam int REQ_W = 2;
    localparam int CNT_W = 11;
    localparam int VP_W = 10;
    localparam int FR_W = 20;
    localparam int ST_W = 2;
    localparam int BASE_W = 10;
    localparam int SLACK_W = 3;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_XLATE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_ZEROMAP = 2'd2;

    localparam logic [0:0] CFG_BASE = 1'b0;
    localparam logic [0:0] CFG_SLACK = 1'b1;

    localparam logic [BASE_W-1:0] BASE_RESET = 10'd64;
    localparam logic [SLACK_W-1:0] SLACK_RESET = 3'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [CNT_W-1:0] page_count;
        logic [VP_W-1:0] virt_page;
        logic [FR_W-1:0] phys_frame;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [FR_W-1:0] result_value;
    } t_rsp;
endpackage
`default_nettype wire

### rtl/core/pra_if.sv
`default_nettype none
interface pra_req_if;
    logic valid;
    logic ready;
    pra_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pra_rsp_if;
    logic valid;
    logic ready;
    pra_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pra_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### rtl/core/pra_store.sv
`default_nettype none
module pra_store #(
    parameter int NUM_PAGES = 1024,
    parameter int AW = 10
) (
    input  wire logic i_clk,
    input  wire logic i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic i_wpres,
    input  wire logic [pra_pkg::FR_W-1:0] i_wframe,
    input  wire logic i_wframe_en,
    input  wire logic [AW-1:0] i_raddr,
    output logic o_rpres,
    output logic [pra_pkg::FR_W-1:0] o_rframe
);
    logic r_pres [NUM_PAGES];
    logic [pra_pkg::FR_W-1:0] r_frame [NUM_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pres[i_waddr] <= i_wpres;
        end
        o_rpres <= r_pres[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_wframe_en) begin
            r_frame[i_waddr] <= i_wframe;
        end
        o_rframe <= r_frame[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/page_run_allocator_top.sv
// page_run_allocator_top: first-fit contiguous virtual page allocator.
// Request channel (i_req) carries req_type, page_count, virt_page and
// phys_frame; response channel (o_rsp) returns status and result_value,
// one response per request. Config channel (i_cfg) writes base_page
// (index 0) and slack_pages (index 1); the user must write them only
// while idle, as the block itself does not enforce it. Present bits and
// frame numbers live in one-port-write, one-port-read memories with
// registered read data; the controller handles one request at a time.
// After reset a clearing pass writes every page, during which no request
// is taken.
// Map and free walk the pages from virt_page, clipped at the end of the page
// space; allocate scans one page per cycle from base_page, then marks the
// pages of the run that it found.
// The response sits in an output register; a stalled receiver holds it and
// the next request is taken once it is delivered.
`default_nettype none
module page_run_allocator_top #(
    parameter int NUM_PAGES = 1024
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    pra_req_if.sink i_req,
    pra_rsp_if.source o_rsp,
    pra_cfg_if.sink i_cfg
);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int PW = ((AW > pra_pkg::VP_W) ? AW : pra_pkg::VP_W) + 1;
    localparam int SW = PW + 1;
    localparam logic [PW-1:0] NP = PW'(NUM_PAGES);
    localparam int CNT_W_L = pra_pkg::CNT_W + 1;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_XL = 3'd5;
    localparam logic [2:0] S_XL2 = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [2:0] r_state, n_state;
    logic [pra_pkg::BASE_W-1:0] r_base;
    logic [pra_pkg::SLACK_W-1:0] r_slack;
    pra_pkg::t_req r_req;
    pra_pkg::t_rsp r_rsp, n_rsp;
    logic [PW-1:0] r_p, n_p;       // scan / walk page
    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_end, n_end;   // walk end (exclusive)
    logic [CNT_W_L-1:0] r_run, n_run;
    logic [pra_pkg::FR_W-1:0] r_fr, n_fr;
    logic r_rdv, n_rdv;            // read data valid for page r_p - 1

    logic we, wpres, wfen, rpres;
    logic [AW-1:0] waddr, raddr;
    logic [pra_pkg::FR_W-1:0] wframe, rframe;
    logic [CNT_W_L-1:0] need;
    logic [SW-1:0] walk_end;

    pra_store #(.NUM_PAGES(NUM_PAGES), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wpres(wpres),
        .i_wframe(wframe), .i_wframe_en(wfen), .i_raddr(raddr),
        .o_rpres(rpres), .o_rframe(rframe)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data = r_rsp;
    assign need = CNT_W_L'(r_req.page_count) + CNT_W_L'(r_slack);
    assign walk_end = SW'(i_req.data.virt_page) + SW'(i_req.data.page_count);

    always_comb begin
        n_state = r_state;
        n_rsp = r_rsp;
        n_p = r_p;
        n_start = r_start;
        n_end = r_end;
        n_run = r_run;
        n_fr = r_fr;
        n_rdv = 1'b0;
        we = 1'b0;
        wpres = 1'b0;
        wfen = 1'b0;
        waddr = r_p[AW-1:0];
        wframe = r_fr;
        raddr = r_p[AW-1:0];
        case (r_state)
            S_CLR: begin
                we = 1'b1;
                wfen = 1'b1;
                wframe = '0;
                n_p = r_p + 1'b1;
                if (r_p == NP - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_rsp = '{status: pra_pkg::ST_OK, result_value: '0};
                    n_fr = i_req.data.phys_frame;
                    n_p = PW'(i_req.data.virt_page);
                    n_end = (walk_end > SW'(NUM_PAGES)) ? NP : PW'(walk_end);
                    case (i_req.data.req_type)
                        pra_pkg::REQ_ALLOC: begin
                            n_p = PW'(r_base);
                            n_start = PW'(r_base);
                            n_run = '0;
                            n_state = S_SCAN;
                        end
                        pra_pkg::REQ_MAP: begin
                            if (i_req.data.page_count == '0) begin
                                n_rsp.status = pra_pkg::ST_ZEROMAP;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        pra_pkg::REQ_FREE: n_state = S_WALK;
                        default: begin
                            if (PW'(i_req.data.virt_page) >= NP) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_XL;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (need == '0) begin
                    n_rsp.result_value = pra_pkg::FR_W'(r_base);
                    n_state = S_OUT;
                end else if (r_rdv && rpres) begin
                    // page r_p-1 used: restart after it, reissue read at r_p
                    n_run = '0;
                    n_start = r_p;
                    n_rdv = 1'b0;
                    if (r_p >= NP) begin
                        n_rsp.status = pra_pkg::ST_NOSPACE;
                        n_state = S_OUT;
                    end else begin
                        n_p = r_p + 1'b1;
                        n_rdv = 1'b1;
                    end
                end else if (r_rdv && (r_run + 1'b1 >= need)) begin
                    n_rsp.result_value = pra_pkg::FR_W'(r_start);
                    n_end = r_p;
                    n_p = r_start;
                    n_state = S_MARK;
                end else begin
                    if (r_rdv) begin
                        n_run = r_run + 1'b1;
                    end
                    if (r_p >= NP) begin
                        n_rsp.status = pra_pkg::ST_NOSPACE;
                        n_state = S_OUT;
                    end else begin
                        n_p = r_p + 1'b1;
                        n_rdv = 1'b1;
                    end
                end
            end
            S_MARK: begin
                we = 1'b1;
                wpres = 1'b1;
                n_p = r_p + 1'b1;
                if (r_p + 1'b1 >= r_end) begin
                    n_state = S_OUT;
                end
            end
            S_WALK: begin
                if (r_p >= r_end) begin
                    n_state = S_OUT;
                end else begin
                    we = 1'b1;
                    wpres = (r_req.req_type == pra_pkg::REQ_MAP);
                    wfen = wpres;
                    n_p = r_p + 1'b1;
                    n_fr = r_fr + 1'b1;
                end
            end
            S_XL: n_state = S_XL2;
            S_XL2: begin
                n_rsp.result_value = rframe;
                n_state = S_OUT;
            end
            default: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_base <= pra_pkg::BASE_RESET;
            r_slack <= pra_pkg::SLACK_RESET;
            r_p <= '0;
            r_rdv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p <= n_p;
            r_rdv <= n_rdv;
            if (i_cfg.valid) begin
                if (i_cfg.index == pra_pkg::CFG_BASE) begin
                    r_base <= i_cfg.wdata[pra_pkg::BASE_W-1:0];
                end else begin
                    r_slack <= i_cfg.wdata[pra_pkg::SLACK_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= i_req.data;
        end
        r_rsp <= n_rsp;
        r_start <= n_start;
        r_end <= n_end;
        r_run <= n_run;
        r_fr <= n_fr;
    end
endmodule
`default_nettype wire

### rtl/core/pra_checker.sv
`default_nettype none
module pra_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [1:0] rsp_status
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with response pending");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("second request taken");
endmodule

bind page_run_allocator_top pra_checker u_pra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_status(o_rsp.data.status)
);
`default_nettype wire

### verif/page_run_allocator_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module page_run_allocator_top_test;
    localparam int NPAGES = 1024;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    pra_req_if req_ch ();
    pra_rsp_if rsp_ch ();
    pra_cfg_if cfg_ch ();

    page_run_allocator_top #(.NUM_PAGES(NPAGES)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    logic [pra_pkg::BASE_W-1:0] base_pg;
    logic [pra_pkg::SLACK_W-1:0] slack_pg;
    logic present_map [NPAGES];
    logic [pra_pkg::FR_W-1:0] frame_map [NPAGES];
    pra_pkg::t_rsp expected_rsp [$];
    int fail_count;
    int idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic pra_pkg::t_rsp compute_rsp(pra_pkg::t_req rq);
        pra_pkg::t_rsp rs;
        int need, run, start, p, pg;
        rs.status = pra_pkg::ST_OK;
        rs.result_value = '0;
        case (rq.req_type)
            pra_pkg::REQ_ALLOC: begin
                need = int'(rq.page_count) + int'(slack_pg);
                if (need == 0) begin
                    rs.result_value = pra_pkg::FR_W'(base_pg);
                end else begin
                    run = 0;
                    start = int'(base_pg);
                    rs.status = pra_pkg::ST_NOSPACE;
                    for (p = int'(base_pg); p < NPAGES; p++) begin
                        if (present_map[p]) begin
                            run = 0;
                            start = p + 1;
                        end else begin
                            run++;
                            if (run >= need) begin
                                for (int k = start; k <= p; k++) present_map[k] = 1'b1;
                                rs.status = pra_pkg::ST_OK;
                                rs.result_value = pra_pkg::FR_W'(start);
                                break;
                            end
                        end
                    end
                end
            end
            pra_pkg::REQ_MAP: begin
                if (rq.page_count == '0) begin
                    rs.status = pra_pkg::ST_ZEROMAP;
                end else begin
                    for (int i = 0; i < int'(rq.page_count); i++) begin
                        pg = int'(rq.virt_page) + i;
                        if (pg >= NPAGES) break;
                        present_map[pg] = 1'b1;
                        frame_map[pg] = rq.phys_frame + pra_pkg::FR_W'(i);
                    end
                end
            end
            pra_pkg::REQ_FREE: begin
                for (int i = 0; i < int'(rq.page_count); i++) begin
                    pg = int'(rq.virt_page) + i;
                    if (pg >= NPAGES) break;
                    present_map[pg] = 1'b0;
                end
            end
            default: rs.result_value = frame_map[rq.virt_page];
        endcase
        return rs;
    endfunction

    task automatic send_req(logic [pra_pkg::REQ_W-1:0] kind, int cnt, int vp, int fr);
        pra_pkg::t_req rq;
        repeat (gap_len() + 1) @(posedge i_clk);
        rq.req_type = kind;
        rq.page_count = pra_pkg::CNT_W'(cnt);
        rq.virt_page = pra_pkg::VP_W'(vp);
        rq.phys_frame = pra_pkg::FR_W'(fr);
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_rsp.push_back(compute_rsp(rq));
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (NPAGES + 20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, int val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= 16'(val);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == pra_pkg::CFG_BASE) base_pg = pra_pkg::BASE_W'(val);
        else slack_pg = pra_pkg::SLACK_W'(val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("response with none pending: %p", rsp_ch.data);
                    fail_count++;
                end else begin
                    pra_pkg::t_rsp ex;
                    ex = expected_rsp.pop_front();
                    if (rsp_ch.data.status !== ex.status) begin
                        $error("status exp %0d got %0d", ex.status, rsp_ch.data.status);
                        fail_count++;
                    end
                    if (rsp_ch.data.result_value !== ex.result_value) begin
                        $error("result_value exp %0h got %0h",
                            ex.result_value, rsp_ch.data.result_value);
                        fail_count++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            g = gap_len();
            if (g == 0 || $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_req(pra_pkg::REQ_XLATE, 0, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 0, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 3, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 1, 0, 0);
        send_req(pra_pkg::REQ_MAP, 0, 5, 7);
        send_req(pra_pkg::REQ_MAP, 4, 1020, 20'hFFFFE);
        send_req(pra_pkg::REQ_XLATE, 0, 1023, 0);
        send_req(pra_pkg::REQ_XLATE, 0, 1021, 0);
        send_req(pra_pkg::REQ_MAP, 2047, 0, 20'hFFFFF);
        send_req(pra_pkg::REQ_ALLOC, 1, 0, 0);
        send_req(pra_pkg::REQ_FREE, 0, 3, 0);
        send_req(pra_pkg::REQ_FREE, 2047, 600, 0);
        send_req(pra_pkg::REQ_FREE, 10, 70, 0);
        send_req(pra_pkg::REQ_ALLOC, 5, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 1024, 0, 0);
        send_req(pra_pkg::REQ_XLATE, 0, 600, 0);
        send_req(pra_pkg::REQ_FREE, 1024, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 1024, 0, 0);
    endtask

    task automatic test_config_extremes();
        drain();
        write_cfg(pra_pkg::CFG_BASE, 1023);
        write_cfg(pra_pkg::CFG_SLACK, 7);
        send_req(pra_pkg::REQ_ALLOC, 0, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 1, 0, 0);
        drain();
        write_cfg(pra_pkg::CFG_SLACK, 0);
        send_req(pra_pkg::REQ_ALLOC, 0, 0, 0);
        send_req(pra_pkg::REQ_ALLOC, 1, 0, 0);
        drain();
        write_cfg(pra_pkg::CFG_BASE, 0);
        send_req(pra_pkg::REQ_ALLOC, 2, 0, 0);
        send_req(pra_pkg::REQ_XLATE, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int kind, cnt;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 149) begin
                drain();
                write_cfg(pra_pkg::CFG_BASE, $urandom_range(0, 3) == 0 ?
                    $urandom_range(0, 1023) : $urandom_range(0, 128));
                write_cfg(pra_pkg::CFG_SLACK, $urandom_range(0, 7));
            end
            kind = $urandom_range(0, 9);
            cnt = $urandom_range(0, 19) == 0 ? $urandom_range(0, 2047)
                : $urandom_range(0, 24);
            if (kind < 4)
                send_req(pra_pkg::REQ_ALLOC, cnt, $urandom, $urandom);
            else if (kind < 6)
                send_req(pra_pkg::REQ_MAP, cnt, $urandom_range(0, 1023), $urandom);
            else if (kind < 8)
                send_req(pra_pkg::REQ_FREE, cnt, $urandom_range(0, 1023), $urandom);
            else
                send_req(pra_pkg::REQ_XLATE, $urandom, $urandom_range(0, 1023), $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        base_pg = pra_pkg::BASE_RESET;
        slack_pg = pra_pkg::SLACK_RESET;
        fail_count = 0;
        idle_cycles = 0;
        for (int i = 0; i < NPAGES; i++) begin
            present_map[i] = 1'b0;
            frame_map[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random(1080);
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
